### src/ready_to_drive_sequencer_assert.svh
// Assertion macros for the ready-to-drive sequencer checker.
`ifndef READY_TO_DRIVE_SEQUENCER_ASSERT_SVH
`define READY_TO_DRIVE_SEQUENCER_ASSERT_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define RTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define RTD_ASSERT_CLK(lbl, prop, msg) `RTD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### src/rtd_pkg.sv
// Package with the types and constants of the ready-to-drive sequencer.
`default_nettype none
package rtd_pkg;

  localparam int MODE_W        = 4;
  localparam int TIME_W        = 32;
  localparam int HOLD_W        = 16;
  localparam int BRAKE_W       = 12;
  localparam int BATT_W        = 2;
  localparam int BOARD_FIELD_W = 4;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [MODE_W-1:0] MODE_IDLE      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_REQUEST   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_PRECHARGE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_INVCHECK  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_READY     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BUTTON    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ERROR     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_BATTCHECK = 4'd8;
  localparam logic [MODE_W-1:0] MODE_DRIVING   = 4'd9;

  localparam logic [BATT_W-1:0] BATT_OTHER       = 2'd0;
  localparam logic [BATT_W-1:0] BATT_READY       = 2'd1;
  localparam logic [BATT_W-1:0] BATT_PRECHARGING = 2'd2;
  localparam logic [BATT_W-1:0] BATT_TS_ACTIVE   = 2'd3;

  localparam logic KIND_EVALUATE = 1'b0;
  localparam logic KIND_RESTART  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRECHARGE_HOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_HOLD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_THRESH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_EN       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATTERY_EN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERTER_EN    = 3'd5;

  typedef struct packed {
    logic [HOLD_W-1:0]  precharge_hold_ms;
    logic [HOLD_W-1:0]  drive_hold_ms;
    logic [BRAKE_W-1:0] brake_threshold;
    logic               brake_check_enable;
    logic               battery_check_enable;
    logic               inverter_check_enable;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [TIME_W-1:0]        now_ms;
    logic                     shutdown_open;
    logic                     heartbeat_ok;
    logic [BATT_W-1:0]        battery_state;
    logic                     precharge_timed_out;
    logic [BOARD_FIELD_W-1:0] board_alive;
    logic [BOARD_FIELD_W-1:0] inverter0_fault;
    logic [BOARD_FIELD_W-1:0] inverter1_fault;
    logic [BRAKE_W-1:0]       brake_level;
    logic                     button_pressed;
  } step_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] press_start;
    logic              press_active;
    logic              blink_enabled;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              mode_changed;
    logic              button_blink_on;
    logic              button_light_on;
    logic              drive_announce;
  } result_t;

endpackage
`default_nettype wire

### src/rtd_if.sv
// Channel interfaces for step samples, results and configuration writes.
`default_nettype none
interface rtd_step_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [rtd_pkg::TIME_W-1:0]        now_ms;
  logic                              shutdown_open;
  logic                              heartbeat_ok;
  logic [rtd_pkg::BATT_W-1:0]        battery_state;
  logic                              precharge_timed_out;
  logic [rtd_pkg::BOARD_FIELD_W-1:0] board_alive;
  logic [rtd_pkg::BOARD_FIELD_W-1:0] inverter0_fault;
  logic [rtd_pkg::BOARD_FIELD_W-1:0] inverter1_fault;
  logic [rtd_pkg::BRAKE_W-1:0]       brake_level;
  logic                              button_pressed;

  modport source (
    output valid, kind, now_ms, shutdown_open, heartbeat_ok, battery_state,
           precharge_timed_out, board_alive, inverter0_fault, inverter1_fault,
           brake_level, button_pressed,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, shutdown_open, heartbeat_ok, battery_state,
           precharge_timed_out, board_alive, inverter0_fault, inverter1_fault,
           brake_level, button_pressed,
    output ready
  );
endinterface

interface rtd_result_if;
  logic                       valid;
  logic                       ready;
  logic [rtd_pkg::MODE_W-1:0] mode;
  logic                       mode_changed;
  logic                       button_blink_on;
  logic                       button_light_on;
  logic                       drive_announce;

  modport source (
    output valid, mode, mode_changed, button_blink_on, button_light_on, drive_announce,
    input  ready
  );
  modport sink (
    input  valid, mode, mode_changed, button_blink_on, button_light_on, drive_announce,
    output ready
  );
endinterface

interface rtd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtd_pkg::CFG_INDEX_W-1:0] index;
  logic [rtd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/rtd_cfg_regs.sv
// Configuration register file of the ready-to-drive sequencer.
`default_nettype none
module rtd_cfg_regs (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rtd_cfg_if.sink      cfg_i,
  output rtd_pkg::cfg_t cfg_o
);

  rtd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        rtd_pkg::CFG_PRECHARGE_HOLD: cfg_d.precharge_hold_ms = cfg_i.data;
        rtd_pkg::CFG_DRIVE_HOLD:     cfg_d.drive_hold_ms = cfg_i.data;
        rtd_pkg::CFG_BRAKE_THRESH:   cfg_d.brake_threshold = cfg_i.data[rtd_pkg::BRAKE_W-1:0];
        rtd_pkg::CFG_BRAKE_EN:       cfg_d.brake_check_enable = cfg_i.data[0];
        rtd_pkg::CFG_BATTERY_EN:     cfg_d.battery_check_enable = cfg_i.data[0];
        rtd_pkg::CFG_INVERTER_EN:    cfg_d.inverter_check_enable = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_hold_ms     <= 16'd1000;
      cfg_q.drive_hold_ms         <= 16'd1000;
      cfg_q.brake_threshold       <= 12'd100;
      cfg_q.brake_check_enable    <= 1'b1;
      cfg_q.battery_check_enable  <= 1'b1;
      cfg_q.inverter_check_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### src/rtd_step_logic.sv
// Next-mode decision logic for one step sample.
`default_nettype none
module rtd_step_logic #(
  parameter int BOARDS = 4
) (
  input  wire rtd_pkg::cfg_t   cfg_i,
  input  wire rtd_pkg::state_t state_i,
  input  wire rtd_pkg::step_t  step_i,
  output rtd_pkg::state_t      state_o,
  output rtd_pkg::result_t     result_o
);

  localparam int MW = (BOARDS > rtd_pkg::BOARD_FIELD_W) ? BOARDS : rtd_pkg::BOARD_FIELD_W;
  localparam logic [MW-1:0] BMASK = MW'((64'd1 << BOARDS) - 64'd1);

  logic [MW-1:0]              alive_ext;
  logic [MW-1:0]              fault_ext;
  logic                       boards_ok;
  logic                       brake_on;
  logic [rtd_pkg::HOLD_W-1:0] hold_sel;
  logic [rtd_pkg::TIME_W-1:0] elapsed;
  logic                       hold_done;
  logic [rtd_pkg::TIME_W-1:0] start_hold;
  logic                       batt_chk;
  rtd_pkg::state_t            nxt;
  logic                       announce;

  assign alive_ext = MW'(step_i.board_alive);
  assign fault_ext = MW'(step_i.inverter0_fault | step_i.inverter1_fault);
  assign boards_ok = ((alive_ext & BMASK) == BMASK) && ((fault_ext & BMASK) == '0);
  assign brake_on  = !cfg_i.brake_check_enable ||
                     (step_i.brake_level >= cfg_i.brake_threshold);
  assign batt_chk  = cfg_i.battery_check_enable;

  // A press that starts on this step has zero elapsed time and never passes.
  assign hold_sel   = (state_i.mode == rtd_pkg::MODE_BUTTON) ? cfg_i.drive_hold_ms
                                                             : cfg_i.precharge_hold_ms;
  assign elapsed    = step_i.now_ms - state_i.press_start;
  assign hold_done  = step_i.button_pressed && state_i.press_active &&
                      (elapsed > rtd_pkg::TIME_W'(hold_sel));
  assign start_hold = (step_i.button_pressed && !state_i.press_active) ? step_i.now_ms
                                                                       : state_i.press_start;

  always_comb begin
    nxt      = state_i;
    announce = 1'b0;
    if (step_i.kind == rtd_pkg::KIND_RESTART) begin
      nxt.mode          = rtd_pkg::MODE_IDLE;
      nxt.blink_enabled = 1'b1;
      nxt.press_active  = 1'b0;
      nxt.press_start   = '0;
    end else if (state_i.mode <= rtd_pkg::MODE_BUTTON) begin
      if (step_i.shutdown_open) begin
        nxt.mode = rtd_pkg::MODE_SHUTDOWN;
      end else if (!step_i.heartbeat_ok) begin
        nxt.mode = rtd_pkg::MODE_ERROR;
      end else begin
        case (state_i.mode)
          rtd_pkg::MODE_IDLE: begin
            if (batt_chk && step_i.battery_state != rtd_pkg::BATT_READY) begin
              nxt.blink_enabled = 1'b0;
              nxt.mode          = rtd_pkg::MODE_BATTCHECK;
            end else begin
              nxt.press_active = step_i.button_pressed;
              nxt.press_start  = start_hold;
              if (hold_done) begin
                nxt.blink_enabled = 1'b0;
                nxt.mode          = rtd_pkg::MODE_REQUEST;
              end
            end
          end
          rtd_pkg::MODE_REQUEST: begin
            if (!batt_chk || step_i.battery_state == rtd_pkg::BATT_PRECHARGING ||
                step_i.battery_state == rtd_pkg::BATT_TS_ACTIVE) begin
              nxt.mode = rtd_pkg::MODE_PRECHARGE;
            end else if (step_i.battery_state != rtd_pkg::BATT_READY) begin
              nxt.mode = rtd_pkg::MODE_BATTCHECK;
            end
          end
          rtd_pkg::MODE_PRECHARGE: begin
            if (!batt_chk || step_i.battery_state == rtd_pkg::BATT_TS_ACTIVE) begin
              nxt.mode = rtd_pkg::MODE_INVCHECK;
            end else if (step_i.battery_state == rtd_pkg::BATT_READY &&
                         step_i.precharge_timed_out) begin
              nxt.mode          = rtd_pkg::MODE_IDLE;
              nxt.blink_enabled = 1'b1;
              nxt.press_active  = 1'b0;
              nxt.press_start   = '0;
            end else if (step_i.battery_state != rtd_pkg::BATT_PRECHARGING) begin
              nxt.mode = rtd_pkg::MODE_BATTCHECK;
            end
          end
          rtd_pkg::MODE_INVCHECK: begin
            if (!cfg_i.inverter_check_enable || boards_ok) begin
              nxt.blink_enabled = 1'b0;
              nxt.mode          = rtd_pkg::MODE_READY;
            end
          end
          rtd_pkg::MODE_READY: begin
            if (brake_on) begin
              nxt.press_active = 1'b0;
              nxt.press_start  = '0;
              nxt.mode         = rtd_pkg::MODE_BUTTON;
            end
          end
          rtd_pkg::MODE_BUTTON: begin
            if (!brake_on) begin
              nxt.blink_enabled = 1'b0;
              nxt.mode          = rtd_pkg::MODE_READY;
            end else begin
              nxt.press_active = step_i.button_pressed;
              nxt.press_start  = start_hold;
              if (hold_done) begin
                announce = 1'b1;
                nxt.mode = rtd_pkg::MODE_DRIVING;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign state_o                  = nxt;
  assign result_o.mode            = nxt.mode;
  assign result_o.mode_changed    = (nxt.mode != state_i.mode);
  assign result_o.button_blink_on = nxt.blink_enabled;
  assign result_o.button_light_on = (nxt.mode == rtd_pkg::MODE_BUTTON);
  assign result_o.drive_announce  = announce;

endmodule
`default_nettype wire

### src/rtd_out_buf.sv
// Two-entry result buffer that decouples the step and result channels.
`default_nettype none
module rtd_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rtd_pkg::result_t data_i,
  output logic                  ready_o,
  rtd_result_if.source          result_o
);

  rtd_pkg::result_t slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign pop     = result_o.valid & result_o.ready;
  assign ready_o = (cnt_q != 2'd2);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign result_o.valid           = (cnt_q != 2'd0);
  assign result_o.mode            = slot_q[rd_q].mode;
  assign result_o.mode_changed    = slot_q[rd_q].mode_changed;
  assign result_o.button_blink_on = slot_q[rd_q].button_blink_on;
  assign result_o.button_light_on = slot_q[rd_q].button_light_on;
  assign result_o.drive_announce  = slot_q[rd_q].drive_announce;

endmodule
`default_nettype wire

### src/ready_to_drive_sequencer.sv
// Top level of the ready-to-drive sequencer.
// The sequencer takes one step transaction per clock cycle and delivers its result from a
// register: the next mode is decided in a single pass of the step logic from the registered
// mode and press timer, and the result lands in a two-entry output buffer, so steps keep
// flowing while the buffer holds a result; the step channel stalls only when both entries
// wait to be taken. Configuration writes are accepted in every cycle.
`default_nettype none
module ready_to_drive_sequencer #(
  parameter int BOARDS = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rtd_step_if.sink     step_i,
  rtd_result_if.source result_o,
  rtd_cfg_if.sink      cfg_i
);

  rtd_pkg::cfg_t    cfg;
  rtd_pkg::step_t   step;
  rtd_pkg::state_t  state_q, state_d;
  rtd_pkg::result_t result;
  logic             buf_ready;
  logic             step_fire;

  assign step.kind                = step_i.kind;
  assign step.now_ms              = step_i.now_ms;
  assign step.shutdown_open       = step_i.shutdown_open;
  assign step.heartbeat_ok        = step_i.heartbeat_ok;
  assign step.battery_state       = step_i.battery_state;
  assign step.precharge_timed_out = step_i.precharge_timed_out;
  assign step.board_alive         = step_i.board_alive;
  assign step.inverter0_fault     = step_i.inverter0_fault;
  assign step.inverter1_fault     = step_i.inverter1_fault;
  assign step.brake_level         = step_i.brake_level;
  assign step.button_pressed      = step_i.button_pressed;

  assign step_i.ready = buf_ready;
  assign step_fire    = step_i.valid & buf_ready;

  rtd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rtd_step_logic #(
    .BOARDS (BOARDS)
  ) u_logic (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .step_i   (step),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= rtd_pkg::MODE_IDLE;
      state_q.press_start   <= '0;
      state_q.press_active  <= 1'b0;
      state_q.blink_enabled <= 1'b1;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  rtd_out_buf u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (step_fire),
    .data_i   (result),
    .ready_o  (buf_ready),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

### src/rtd_checker.sv
// Port-level assertion checker for the ready-to-drive sequencer and its bind.
`default_nettype none
`include "ready_to_drive_sequencer_assert.svh"
module rtd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rtd_pkg::MODE_W-1:0] mode,
  input wire logic                       mode_changed,
  input wire logic                       blink_on,
  input wire logic                       light_on,
  input wire logic                       announce
);

  `RTD_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(mode), "stalled result changed")
  `RTD_ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "step channel stalled with empty buffer")
  `RTD_ASSERT_CLK(a_announce_enters_driving, out_valid && announce |-> mode == rtd_pkg::MODE_DRIVING && mode_changed, "announce outside driving entry")
  `RTD_ASSERT_CLK(a_light_is_button, out_valid |-> light_on == (mode == rtd_pkg::MODE_BUTTON), "button light disagrees with mode")
  `RTD_ASSERT_CLK(a_idle_blinks, out_valid && mode == rtd_pkg::MODE_IDLE |-> blink_on, "idle mode without blinking")

endmodule

bind ready_to_drive_sequencer rtd_checker u_rtd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (step_i.ready),
  .out_valid    (result_o.valid),
  .out_ready    (result_o.ready),
  .mode         (result_o.mode),
  .mode_changed (result_o.mode_changed),
  .blink_on     (result_o.button_blink_on),
  .light_on     (result_o.button_light_on),
  .announce     (result_o.drive_announce)
);
`default_nettype wire
